// File: hdl/snt_pkg.sv
// ----------------------------------------------------------------------------
// snt_pkg
// Shared types, constants and the sigmoid table of the sigmoid neuron trainer.
// ----------------------------------------------------------------------------
package snt_pkg;

  localparam int MaxDim   = 16;
  localparam int IdxW     = $clog2(MaxDim);
  localparam int CntW     = IdxW + 1;
  localparam int DivW     = 48;
  localparam int RootSteps = 32;

  // input kinds on tuser
  localparam logic ACT_WEIGHT = 1'b0;
  localparam logic ACT_FEED   = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_DIMENSION  = 2'd0;
  localparam logic [1:0] REG_SLOPE      = 2'd1;
  localparam logic [1:0] REG_LEARN_RATE = 2'd2;

  // shared unit operation
  localparam logic OP_ROOT = 1'b0;
  localparam logic OP_DIV  = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } unit_req_t;

  // sigmoid samples at 0.5 spacing on [0, 8], Q0.16
  function automatic logic [15:0] sig_tab(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd40793;
      5'd2:    v = 16'd47911;
      5'd3:    v = 16'd53581;
      5'd4:    v = 16'd57724;
      5'd5:    v = 16'd60565;
      5'd6:    v = 16'd62428;
      5'd7:    v = 16'd63615;
      5'd8:    v = 16'd64357;
      5'd9:    v = 16'd64816;
      5'd10:   v = 16'd65097;
      5'd11:   v = 16'd65269;
      5'd12:   v = 16'd65374;
      5'd13:   v = 16'd65438;
      5'd14:   v = 16'd65476;
      5'd15:   v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/snt_root_div.sv
// ----------------------------------------------------------------------------
// snt_root_div
// Iterative unit: 64-bit integer square root (two bits a cycle) or
// 48 by 32 bit restoring division (one quotient bit a cycle).
// ----------------------------------------------------------------------------
module snt_root_div (
  input  logic                      clk,
  input  logic                      rst,
  input  snt_pkg::unit_req_t        req,
  input  logic [63:0]               operand,
  input  logic [31:0]               divisor,
  output logic                      done,
  output logic [snt_pkg::DivW-1:0]  result
);

  logic        busy;
  logic        op;
  logic [5:0]  step;
  logic [63:0] acc;
  logic [63:0] res;
  logic [31:0] dvs;

  logic [63:0] bitv;
  logic [63:0] trial;
  logic [32:0] rem_sh;

  // trial values for both operations
  always_comb begin
    bitv   = 64'd1 << {step[4:0], 1'b0};
    trial  = res + bitv;
    rem_sh = {res[31:0], acc[snt_pkg::DivW-1]};
  end

  // iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == 6'd0);
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        acc  <= operand;
        res  <= 64'd0;
        dvs  <= divisor;
        step <= (req.op == snt_pkg::OP_ROOT) ? 6'(snt_pkg::RootSteps - 1)
                                             : 6'(snt_pkg::DivW - 1);
      end else if (busy) begin
        if (op == snt_pkg::OP_ROOT) begin
          if (acc >= trial) begin
            acc <= acc - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
        end else begin
          if (rem_sh >= {1'b0, dvs}) begin
            res <= {31'd0, rem_sh - {1'b0, dvs}};
            acc <= {acc[62:0], 1'b1};
          end else begin
            res <= {31'd0, rem_sh};
            acc <= {acc[62:0], 1'b0};
          end
        end
        if (step == 6'd0) begin
          busy <= 1'b0;
        end else begin
          step <= step - 6'd1;
        end
      end
    end
  end

  assign result = (op == snt_pkg::OP_ROOT) ? {16'd0, res[31:0]}
                                           : acc[snt_pkg::DivW-1:0];

endmodule

// File: hdl/sigmoid_neuron_trainer.sv
// ----------------------------------------------------------------------------
// sigmoid_neuron_trainer
// Single sigmoid neuron with stored weights and normalized-gradient training.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: tuser = 0 writes one weight at index, tuser = 1 feeds one
//   input element; tlast on a feed ends the vector. Only a feed with tlast
//   gives an m_* word (activation and updated flag).
//   cfg_* channel writes dimension, slope or learn_rate; always ready.
//   Sequence: a weight write is taken in the idle state; a feed element
//   runs the product, square and accumulate steps (one shared 33x33
//   multiplier is used for the product and the square). Ending a vector
//   adds sigmoid scale, interpolate and output steps on the same multiplier;
//   with training, the shared root/divide unit then finds the norm and,
//   per received element, runs multiply, 48-step divide and weight write.
//   s_tready is high only while the sequencer is idle.
//   The result sits in an output register; the next vector is accepted while
//   it waits, and the sequencer holds before the following result until the
//   receiver takes the earlier one.
//   Reset: weights and accumulators clear, dimension = 16, slope = 256,
//   learn_rate = 655, no word pending.
// ----------------------------------------------------------------------------
module sigmoid_neuron_trainer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // index[3:0], value[35:4], train[36], target[52:37]
  input  logic        s_tuser,   // action
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // activation[15:0], updated[16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_MUL_SQ     = 4'd1;
  localparam logic [3:0] ST_ACC_SQ     = 4'd2;
  localparam logic [3:0] ST_SIG_SCALE  = 4'd3;
  localparam logic [3:0] ST_SIG_INTERP = 4'd4;
  localparam logic [3:0] ST_SIG_OUT    = 4'd5;
  localparam logic [3:0] ST_ROOT       = 4'd6;
  localparam logic [3:0] ST_STEP_MUL   = 4'd7;
  localparam logic [3:0] ST_STEP_START = 4'd8;
  localparam logic [3:0] ST_STEP_DIV   = 4'd9;
  localparam logic [3:0] ST_STEP_WR    = 4'd10;
  localparam logic [3:0] ST_DONE       = 4'd11;

  logic [3:0]  state;
  logic [4:0]  dimension;
  logic [15:0] slope;
  logic [15:0] learn_rate;

  logic signed [31:0] weights [snt_pkg::MaxDim];
  logic signed [31:0] input_store [snt_pkg::MaxDim];
  logic [63:0] dot;
  logic [63:0] sq;
  logic [snt_pkg::CntW-1:0] count;
  logic [snt_pkg::CntW-1:0] walk;
  logic [63:0] prod;
  logic signed [31:0] x_l;
  logic        last_l;
  logic        train_l;
  logic [15:0] target_l;
  logic [4:0]  sidx;
  logic [15:0] act;
  logic        upd;
  logic [31:0] norm;

  // input fields
  logic [3:0]  in_index;
  logic signed [31:0] in_value;
  logic        in_train;
  logic [15:0] in_target;
  assign in_index  = s_tdata[3:0];
  assign in_value  = s_tdata[35:4];
  assign in_train  = s_tdata[36];
  assign in_target = s_tdata[52:37];

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  logic [snt_pkg::CntW-1:0] eff;
  logic        neg;
  logic [63:0] mag;
  logic [27:0] m_cl;
  logic [55:0] t_full;
  logic [19:0] t_cl;
  logic [4:0]  t_idx;
  logic [15:0] diff;
  logic [16:0] v;
  logic [16:0] act_full;
  logic        do_update;
  logic signed [31:0] xw;
  logic [31:0] ax;
  logic        pos_err;
  logic        dec;
  logic signed [49:0] w_wide;
  logic signed [49:0] w_new;
  logic [31:0] w_sat;
  logic [64:0] dot_sum;
  logic [63:0] dot_sat;
  logic [64:0] sq_sum;

  snt_pkg::unit_req_t unit_req;
  logic        unit_done;
  logic [snt_pkg::DivW-1:0] unit_result;
  logic [63:0] unit_operand;

  assign eff = (dimension > 5'(snt_pkg::MaxDim)) ? snt_pkg::CntW'(snt_pkg::MaxDim)
                                                 : snt_pkg::CntW'(dimension);
  assign xw  = input_store[walk[snt_pkg::IdxW-1:0]];
  assign ax  = xw[31] ? 32'(-xw) : 32'(xw);

  // operand select for the multiplier
  always_comb begin
    case (state)
      ST_IDLE: begin
        mul_a = 33'(weights[count[snt_pkg::IdxW-1:0]]);
        mul_b = 33'(in_value);
      end
      ST_MUL_SQ: begin
        mul_a = 33'(x_l);
        mul_b = 33'(x_l);
      end
      ST_SIG_SCALE: begin
        mul_a = {5'd0, m_cl};
        mul_b = {17'd0, slope};
      end
      ST_SIG_INTERP: begin
        mul_a = {17'd0, diff};
        mul_b = {18'd0, t_cl[14:0]};
      end
      default: begin
        mul_a = {17'd0, learn_rate};
        mul_b = {1'b0, ax};
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // sigmoid argument, interpolation and result
  always_comb begin
    neg    = dot[63];
    mag    = neg ? (64'd0 - dot) : dot;
    m_cl   = (mag[63:16] > 48'd134217728) ? 28'd134217728 : mag[43:16];
    t_full = prod[63:8];
    t_cl   = (t_full > 56'd524288) ? 20'd524288 : t_full[19:0];
    t_idx  = t_cl[19:15];
    diff   = (t_idx >= 5'd16) ? 16'd0
                              : snt_pkg::sig_tab(t_idx + 5'd1) - snt_pkg::sig_tab(t_idx);
    v      = (sidx >= 5'd16) ? {1'b0, snt_pkg::sig_tab(5'd16)}
                             : {1'b0, snt_pkg::sig_tab(sidx)} + 17'(prod[31:15]);
    act_full = neg ? (17'd65536 - v) : v;
    if (act_full > 17'd65535) begin
      act_full = 17'd65535;
    end
    do_update = train_l && (act_full[15:0] != target_l) && (slope != 16'd0) &&
                (act_full[15:0] != 16'd0) && (sq != 64'd0);
  end

  // accumulators with saturation
  always_comb begin
    dot_sum = {dot[63], dot} + {prod[63], prod};
    if (dot_sum[64] != dot_sum[63]) begin
      dot_sat = dot_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      dot_sat = dot_sum[63:0];
    end
    sq_sum = {1'b0, sq} + {1'b0, prod};
  end

  // weight step with saturation
  always_comb begin
    pos_err = act > target_l;
    dec     = xw[31] ? !pos_err : pos_err;
    w_wide  = 50'(weights[walk[snt_pkg::IdxW-1:0]]);
    w_new   = dec ? (w_wide - {2'b00, unit_result}) : (w_wide + {2'b00, unit_result});
    if (w_new > 50'sh7FFFFFFF) begin
      w_sat = 32'h7FFFFFFF;
    end else if (w_new < -50'sh80000000) begin
      w_sat = 32'h80000000;
    end else begin
      w_sat = w_new[31:0];
    end
  end

  // requests to the root/divide unit
  always_comb begin
    unit_req.start = 1'b0;
    unit_req.op    = snt_pkg::OP_ROOT;
    unit_operand   = sq;
    if (state == ST_SIG_OUT && do_update) begin
      unit_req.start = 1'b1;
    end else if (state == ST_STEP_START) begin
      unit_req.start = 1'b1;
      unit_req.op    = snt_pkg::OP_DIV;
      unit_operand   = {16'd0, prod[47:0]};
    end
  end

  snt_root_div u_root_div (
    .clk     (clk),
    .rst     (rst),
    .req     (unit_req),
    .operand (unit_operand),
    .divisor (norm),
    .done    (unit_done),
    .result  (unit_result)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dimension  <= 5'd16;
      slope      <= 16'd256;
      learn_rate <= 16'd655;
    end else if (cfg_valid) begin
      case (cfg_index)
        snt_pkg::REG_DIMENSION:  dimension  <= cfg_data[4:0];
        snt_pkg::REG_SLOPE:      slope      <= cfg_data;
        snt_pkg::REG_LEARN_RATE: learn_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // element store, written only by feeds
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid && s_tuser == snt_pkg::ACT_FEED && count < eff) begin
      input_store[count[snt_pkg::IdxW-1:0]] <= in_value;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      dot      <= 64'd0;
      sq       <= 64'd0;
      count    <= '0;
      m_tvalid <= 1'b0;
      for (int k = 0; k < snt_pkg::MaxDim; k++) begin
        weights[k] <= 32'd0;
      end
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == snt_pkg::ACT_WEIGHT) begin
              weights[in_index] <= in_value;
            end else begin
              last_l   <= s_tlast;
              train_l  <= in_train;
              target_l <= in_target;
              if (count < eff) begin
                prod  <= mul_p[63:0];
                x_l   <= in_value;
                count <= count + 1'b1;
                state <= ST_MUL_SQ;
              end else if (s_tlast) begin
                state <= ST_SIG_SCALE;
              end
            end
          end
        end
        ST_MUL_SQ: begin
          dot   <= dot_sat;
          prod  <= mul_p[63:0];
          state <= ST_ACC_SQ;
        end
        ST_ACC_SQ: begin
          sq    <= sq_sum[64] ? {64{1'b1}} : sq_sum[63:0];
          state <= last_l ? ST_SIG_SCALE : ST_IDLE;
        end
        ST_SIG_SCALE: begin
          prod  <= mul_p[63:0];
          state <= ST_SIG_INTERP;
        end
        ST_SIG_INTERP: begin
          sidx  <= t_idx;
          prod  <= mul_p[63:0];
          state <= ST_SIG_OUT;
        end
        ST_SIG_OUT: begin
          act   <= act_full[15:0];
          upd   <= do_update;
          walk  <= '0;
          state <= do_update ? ST_ROOT : ST_DONE;
        end
        ST_ROOT: begin
          if (unit_done) begin
            norm  <= unit_result[31:0];
            state <= ST_STEP_MUL;
          end
        end
        ST_STEP_MUL: begin
          prod  <= mul_p[63:0];
          state <= ST_STEP_START;
        end
        ST_STEP_START: begin
          state <= ST_STEP_DIV;
        end
        ST_STEP_DIV: begin
          if (unit_done) begin
            state <= ST_STEP_WR;
          end
        end
        ST_STEP_WR: begin
          weights[walk[snt_pkg::IdxW-1:0]] <= w_sat;
          walk  <= walk + 1'b1;
          state <= (walk + 1'b1 == count) ? ST_DONE : ST_STEP_MUL;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, upd, act};
            dot      <= 64'd0;
            sq       <= 64'd0;
            count    <= '0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
